FILE: design/ect_pkg.sv
// Shared types and constants for the extent coverage tracker.
`timescale 1ns / 1ps
package ect_pkg;
	localparam int ADDR_W = 48;
	localparam int LEN_W = 32;
	localparam int DEFAULT_MAX_RUNS = 64;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BELOW   = 3'd1;
	localparam logic [2:0] ST_SPAN    = 3'd2;
	localparam logic [2:0] ST_OVERLAP = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_FAILED  = 3'd5;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_SPAN = 1'b1;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic              insert;
		logic              shift_out;
		logic              merge_hi;
		logic              merge_lo;
		logic [ADDR_W-1:0] s;
		logic [ADDR_W-1:0] e;
	} ect_cmd_t;

	// Per-cell view of the incoming extent.
	typedef struct packed {
		logic le_s;
		logic end_gt_s;
		logic end_eq_s;
		logic start_lt_e;
		logic start_eq_e;
	} ect_flag_t;
endpackage

FILE: design/ect_cell.sv
// One run slot of the sorted run chain.
`timescale 1ns / 1ps
module ect_cell (
	input  logic                      clk,
	input  logic                      occupied,
	input  logic                      left_before,
	input  logic [ect_pkg::ADDR_W-1:0] left_start,
	input  logic [ect_pkg::ADDR_W-1:0] left_end,
	input  logic                      right_after,
	input  logic [ect_pkg::ADDR_W-1:0] right_start,
	input  logic [ect_pkg::ADDR_W-1:0] right_end,
	input  ect_pkg::ect_cmd_t          cmd,
	output logic                      le_start,
	output logic [ect_pkg::ADDR_W-1:0] start_q,
	output logic [ect_pkg::ADDR_W-1:0] end_q,
	output ect_pkg::ect_flag_t        flags
);
	import ect_pkg::*;

	logic is_pos;
	logic is_prev;

	assign le_start = occupied && (start_q <= cmd.s);
	assign is_pos = occupied && !le_start && left_before;
	assign is_prev = le_start && !right_after;

	assign flags.le_s       = le_start;
	assign flags.end_gt_s   = occupied && (end_q > cmd.s);
	assign flags.end_eq_s   = occupied && (end_q == cmd.s);
	assign flags.start_lt_e = occupied && (start_q < cmd.e);
	assign flags.start_eq_e = occupied && (start_q == cmd.e);

	// Insert: cells after the slot take their left neighbor; the slot takes the extent.
	// Shift out: cells at or after the removed slot take their right neighbor.
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (!le_start) begin
				if (left_before) begin
					start_q <= cmd.s;
					end_q   <= cmd.e;
				end else begin
					start_q <= left_start;
					end_q   <= left_end;
				end
			end
		end else if (cmd.shift_out) begin
			if (is_prev) begin
				end_q <= right_end;
			end else if (!le_start && occupied) begin
				start_q <= right_start;
				end_q   <= right_end;
			end
		end else if (cmd.merge_hi) begin
			if (is_prev && flags.end_eq_s) end_q <= cmd.e;
		end else if (cmd.merge_lo) begin
			if (is_pos && flags.start_eq_e) start_q <= cmd.s;
		end
	end
endmodule

FILE: design/extent_coverage_tracker.sv
// Top level of the extent coverage tracker: run cell chain and step control.
// A request is taken into the input registers and evaluated once the output register
// is free or being drained; its result is registered at the end of the evaluating cycle.
// A new request is not taken until the current one is evaluated; a result held in the
// output register stalls the next evaluation. Cells compare in parallel, shift together.
// Reset clears run count, totals, high mark and the failed flag; runs need none.
`timescale 1ns / 1ps
module extent_coverage_tracker #(
	parameter int MAX_RUNS = ect_pkg::DEFAULT_MAX_RUNS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [ect_pkg::ADDR_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [ect_pkg::ADDR_W-1:0] extent_offset,
	input  logic [ect_pkg::LEN_W-1:0]  extent_length,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                status,
	output logic [6:0]                runs_held,
	output logic [ect_pkg::ADDR_W-1:0] high_mark,
	output logic [ect_pkg::ADDR_W-1:0] bytes_covered,
	output logic                      complete
);
	import ect_pkg::*;
	localparam int CW = $clog2(MAX_RUNS + 1);

	logic [ADDR_W-1:0] base_q, span_q, hw_q, total_q, s_q, e_q;
	logic [LEN_W-1:0] len_q;
	logic [CW-1:0] cnt_q;
	logic failed_q, busy_q, ovf_q;

	ect_cmd_t cmd;
	logic [MAX_RUNS-1:0] occ, bef;
	logic [MAX_RUNS-1:0] lbef, rbef;
	logic [ADDR_W-1:0] st [MAX_RUNS];
	logic [ADDR_W-1:0] en [MAX_RUNS];
	ect_flag_t fl [MAX_RUNS];
	logic [MAX_RUNS-1:0] prev_ov, pos_ov, prev_eq, pos_eq;

	genvar g;
	generate
		for (g = 0; g < MAX_RUNS; g++) begin : g_cell
			assign occ[g] = CW'(g) < cnt_q;
			assign lbef[g] = (g == 0) ? 1'b1 : bef[g-1];
			assign rbef[g] = (g == MAX_RUNS - 1) ? 1'b0 : bef[g+1];
			ect_cell u_cell (
				.clk(clk), .occupied(occ[g]),
				.left_before(lbef[g]),
				.left_start((g == 0) ? s_q : st[(g == 0) ? 0 : g-1]),
				.left_end((g == 0) ? e_q : en[(g == 0) ? 0 : g-1]),
				.right_after(rbef[g]),
				.right_start(st[(g == MAX_RUNS - 1) ? g : g+1]),
				.right_end(en[(g == MAX_RUNS - 1) ? g : g+1]),
				.cmd(cmd), .le_start(bef[g]), .start_q(st[g]), .end_q(en[g]),
				.flags(fl[g]));
			// prev = last cell at or below s; pos = first cell above s
			assign prev_ov[g] = bef[g] && !rbef[g] && fl[g].end_gt_s;
			assign prev_eq[g] = bef[g] && !rbef[g] && fl[g].end_eq_s;
			assign pos_ov[g]  = occ[g] && !bef[g] && lbef[g] && fl[g].start_lt_e;
			assign pos_eq[g]  = occ[g] && !bef[g] && lbef[g] && fl[g].start_eq_e;
		end
	endgenerate

	logic any_ov, m_lo, m_hi, full, below, span_bad, zero_len, eval, go;
	logic [2:0] st_n;
	logic [ADDR_W:0] e_minus_b;
	assign any_ov = |prev_ov || |pos_ov;
	assign m_lo = |prev_eq;
	assign m_hi = |pos_eq;
	assign full = cnt_q == CW'(MAX_RUNS);
	assign below = s_q < base_q;
	assign e_minus_b = {1'b0, e_q} - {1'b0, base_q};
	assign span_bad = ovf_q || ((span_q != '0) && (e_minus_b > {1'b0, span_q}));
	assign zero_len = len_q == '0;

	always_comb begin
		if (failed_q) st_n = ST_FAILED;
		else if (below) st_n = ST_BELOW;
		else if (span_bad) st_n = ST_SPAN;
		else if (zero_len) st_n = ST_OK;
		else if (any_ov) st_n = ST_OVERLAP;
		else if (!m_lo && !m_hi && full) st_n = ST_FULL;
		else st_n = ST_OK;
	end
	// Evaluate once the output register is free or being drained.
	assign eval = busy_q && (!out_valid || !out_stall);
	assign go = eval && st_n == ST_OK && !zero_len;

	always_comb begin
		cmd.s = s_q;
		cmd.e = e_q;
		cmd.insert = go && !m_lo && !m_hi;
		cmd.shift_out = go && m_lo && m_hi;
		cmd.merge_hi = go && m_lo && !m_hi;
		cmd.merge_lo = go && !m_lo && m_hi;
	end

	logic done_n;
	logic [CW-1:0] cnt_n;
	logic [ADDR_W-1:0] hw_n, total_n, first_s, first_e;
	assign cnt_n = cmd.insert ? cnt_q + 1'b1 : cmd.shift_out ? cnt_q - 1'b1 : cnt_q;
	assign hw_n = (go && e_q > hw_q) ? e_q : hw_q;
	assign total_n = go ? total_q + ADDR_W'(len_q) : total_q;
	// first run after this request; only looked at when one run remains
	assign first_s = (cmd.insert || cmd.merge_lo) ? s_q : st[0];
	assign first_e = (cmd.insert || cmd.merge_hi) ? e_q : cmd.shift_out ? en[1] : en[0];
	assign done_n = (hw_n == base_q) ||
		((cnt_n == CW'(1)) && first_s == base_q && first_e == hw_n);

	assign in_stall = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; out_valid <= 1'b0; failed_q <= 1'b0;
			cnt_q <= '0; hw_q <= '0; total_q <= '0;
			base_q <= '0; span_q <= '0;
			s_q <= '0; e_q <= '0; len_q <= '0; ovf_q <= 1'b0;
			status <= ST_OK; runs_held <= '0; high_mark <= '0;
			bytes_covered <= '0; complete <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_BASE) begin
					base_q <= cfg_data; hw_q <= cfg_data;
				end else span_q <= cfg_data;
			end
			if (in_valid && !busy_q) begin
				busy_q <= 1'b1;
				s_q <= extent_offset;
				len_q <= extent_length;
				{ovf_q, e_q} <= {1'b0, extent_offset} + (ADDR_W+1)'(extent_length);
			end
			if (eval) begin
				busy_q <= 1'b0;
				out_valid <= 1'b1;
				status <= st_n;
				runs_held <= 7'(cnt_n);
				high_mark <= hw_n;
				bytes_covered <= total_n;
				complete <= done_n;
				if (st_n == ST_SPAN || st_n == ST_FULL) failed_q <= 1'b1;
				cnt_q <= cnt_n;
				hw_q <= hw_n;
				total_q <= total_n;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule

FILE: design/ect_checker.sv
// Port-level checker for the extent coverage tracker, bound to the top level.
`timescale 1ns / 1ps
module ect_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status
);
	import ect_pkg::*;

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second request taken while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (status == ST_SPAN || status == ST_FULL ||
		status == ST_FAILED) ##1 out_valid[->1] |-> status == ST_FAILED)
		else $error("failed state not sticky");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FAILED) else $error("bad status code");
endmodule

bind extent_coverage_tracker ect_checker u_ect_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status));
